[rtl/core/sel_pkg.sv]
`timescale 1ns / 1ps

package sel_pkg;

  localparam int unsigned CfgWidth  = 10;
  localparam int unsigned LineWidth = 20;
  localparam logic [CfgWidth-1:0]  MaxIdLengthReset = 10'd127;
  localparam logic [LineWidth-1:0] LineMax          = 20'hFFFFF;

  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChVt     = 8'h0B;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChBar    = 8'h7C;

  typedef enum logic [2:0] {
    TOK_LBRACKET = 3'd0,
    TOK_RBRACKET = 3'd1,
    TOK_IDENT    = 3'd2,
    TOK_NUMBER   = 3'd3,
    TOK_EOI      = 3'd4
  } token_kind_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } char_t;

  typedef struct packed {
    logic [2:0]           token_kind;
    logic [7:0]           text_byte;
    logic                 text_valid;
    logic                 token_end;
    logic                 length_limited;
    logic [LineWidth-1:0] line_number;
  } token_t;

endpackage

[rtl/core/s_expression_lexer.sv]
`timescale 1ns / 1ps
// Results are registered into the result queue below and shown on tok in order.
// Throughput: one request per cycle; a request yields zero to two results, which
// leave one per cycle while tok_ready is high from a four-entry result queue, so
// requests stall only while the queue holds three or more results.
// Reset (rst, synchronous): lexer idle, line count zero, queue empty, limit 127.
module s_expression_lexer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [sel_pkg::CfgWidth-1:0] cfg_data,
  input  logic                       char_valid,
  output logic                       char_ready,
  input  sel_pkg::char_t             char_req,
  output logic                       tok_valid,
  input  logic                       tok_ready,
  output sel_pkg::token_t            tok
);
  import sel_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_COLON,
    MODE_TEXT,
    MODE_QUOTED
  } mode_t;

  logic [CfgWidth-1:0]  max_id_length;
  mode_t                mode, mode_next;
  logic [7:0]           held_char, held_char_next;
  logic                 held_valid, held_valid_next;
  logic                 is_number, is_number_next;
  logic [CfgWidth-1:0]  text_count, text_count_next;
  logic [LineWidth-1:0] line_count, line_count_next;

  token_t               fifo [4];
  logic [1:0]           wr_ptr, rd_ptr;
  logic [2:0]           fill;

  logic [7:0]           c;
  logic                 eoi;
  logic [CfgWidth-1:0]  lim_eff;
  logic                 lim_hit;
  logic                 is_space, ends_bare;
  logic [2:0]           text_kind;
  logic                 first_v, second_v;
  token_t               first_res, second_res;
  token_t               res0, res1;
  logic [1:0]           n_res;
  logic                 accept, pop;

  assign c         = char_req.char_byte;
  assign eoi       = char_req.end_of_input;
  assign lim_eff   = (max_id_length == '0) ? CfgWidth'(1) : max_id_length;
  assign lim_hit   = text_count >= lim_eff;
  assign is_space  = (c == ChSpace) || (c == ChTab) || (c == ChNl) || (c == ChVt)
                     || (c == ChFf) || (c == ChCr);
  assign ends_bare = is_space || (c == ChLParen) || (c == ChRParen) || (c == ChSemi)
                     || (c == ChBar);
  assign text_kind = is_number ? TOK_NUMBER : TOK_IDENT;

  assign cfg_ready  = 1'b1;
  assign char_ready = (fill <= 3'd2);
  assign accept     = char_valid && char_ready;
  assign tok_valid  = (fill != 3'd0);
  assign tok        = fifo[rd_ptr];
  assign pop        = tok_valid && tok_ready;

  always_comb begin
    logic do_finish;
    logic do_append;
    logic run_idle;
    mode_next       = mode;
    held_char_next  = held_char;
    held_valid_next = held_valid;
    is_number_next  = is_number;
    text_count_next = text_count;
    line_count_next = line_count;
    do_finish       = 1'b0;
    do_append       = 1'b0;
    run_idle        = 1'b0;
    first_v         = 1'b0;
    second_v        = 1'b0;
    first_res       = '{token_kind: text_kind, text_byte: held_char, text_valid: 1'b1,
                        token_end: 1'b0, length_limited: 1'b0, line_number: line_count};
    second_res      = '{token_kind: TOK_EOI, text_byte: 8'd0, text_valid: 1'b0,
                        token_end: 1'b1, length_limited: 1'b0, line_number: line_count};

    case (mode)
      MODE_COMMENT: begin
        if (eoi) begin
          mode_next = MODE_IDLE;
          second_v  = 1'b1;
        end else if (c == ChNl) begin
          if (line_count != LineMax) line_count_next = line_count + 1'b1;
          mode_next = MODE_IDLE;
        end
      end
      MODE_COLON: begin
        if (eoi) begin
          do_finish = 1'b1;
          run_idle  = 1'b1;
        end else begin
          is_number_next  = 1'b0;
          held_char_next  = c;
          held_valid_next = 1'b1;
          text_count_next = CfgWidth'(1);
          mode_next       = MODE_TEXT;
        end
      end
      MODE_TEXT: begin
        if (!eoi && !ends_bare) begin
          do_append = 1'b1;
        end else begin
          do_finish = 1'b1;
          run_idle  = 1'b1;
        end
      end
      MODE_QUOTED: begin
        if (eoi) begin
          do_finish = 1'b1;
          run_idle  = 1'b1;
        end else if (c == ChBar) begin
          do_finish = 1'b1;
        end else begin
          do_append = 1'b1;
        end
      end
      default: run_idle = 1'b1;
    endcase

    // drop text beyond the limit
    if (do_append && !lim_hit) begin
      first_v         = held_valid;
      held_char_next  = c;
      held_valid_next = 1'b1;
      text_count_next = text_count + 1'b1;
    end

    if (do_finish) begin
      first_v         = 1'b1;
      first_res       = '{token_kind: text_kind, text_byte: held_valid ? held_char : 8'd0,
                          text_valid: held_valid, token_end: 1'b1,
                          length_limited: lim_hit, line_number: line_count};
      held_valid_next = 1'b0;
      held_char_next  = 8'd0;
      text_count_next = '0;
      is_number_next  = 1'b0;
      mode_next       = MODE_IDLE;
    end

    // the terminating character is taken again as the start of the next token
    if (run_idle) begin
      if (eoi) begin
        second_v = 1'b1;
      end else if ((c == ChSpace) || (c == ChTab) || (c == ChCr)) begin
        mode_next = MODE_IDLE;
      end else if (c == ChNl) begin
        if (line_count != LineMax) line_count_next = line_count + 1'b1;
      end else if (c == ChSemi) begin
        mode_next = MODE_COMMENT;
      end else if (c == ChLParen) begin
        second_v              = 1'b1;
        second_res.token_kind = TOK_LBRACKET;
      end else if (c == ChRParen) begin
        second_v              = 1'b1;
        second_res.token_kind = TOK_RBRACKET;
      end else begin
        held_valid_next = 1'b0;
        held_char_next  = 8'd0;
        text_count_next = '0;
        is_number_next  = 1'b0;
        if (c == ChColon) begin
          mode_next = MODE_COLON;
        end else if (c == ChBar) begin
          mode_next = MODE_QUOTED;
        end else begin
          is_number_next  = (c >= ChZero) && (c <= ChNine);
          held_char_next  = c;
          held_valid_next = 1'b1;
          text_count_next = CfgWidth'(1);
          mode_next       = MODE_TEXT;
        end
      end
    end

    res0  = first_v ? first_res : second_res;
    res1  = second_res;
    n_res = {1'b0, first_v} + {1'b0, second_v};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_id_length <= MaxIdLengthReset;
      mode          <= MODE_IDLE;
      held_char     <= 8'd0;
      held_valid    <= 1'b0;
      is_number     <= 1'b0;
      text_count    <= '0;
      line_count    <= '0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      fill          <= '0;
    end else begin
      if (cfg_valid) max_id_length <= cfg_data;
      if (accept) begin
        mode       <= mode_next;
        held_char  <= held_char_next;
        held_valid <= held_valid_next;
        is_number  <= is_number_next;
        text_count <= text_count_next;
        line_count <= line_count_next;
        wr_ptr     <= wr_ptr + n_res;
      end
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (accept ? {1'b0, n_res} : 3'd0) - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (n_res != 2'd0)) fifo[wr_ptr] <= res0;
    if (accept && (n_res == 2'd2)) fifo[wr_ptr + 2'd1] <= res1;
  end

endmodule

[verif/token_checker.sv]
`timescale 1ns / 1ps
module token_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [sel_pkg::CfgWidth-1:0] cfg_data,
  input  logic                         char_valid,
  input  logic                         char_ready,
  input  sel_pkg::char_t               char_req,
  input  logic                         tok_valid,
  input  logic                         tok_ready,
  input  sel_pkg::token_t              tok,
  output int                           outstanding,
  output int                           mismatches
);
  import sel_pkg::*;

  typedef enum logic [2:0] {
    LM_IDLE,
    LM_COMMENT,
    LM_COLON,
    LM_TEXT,
    LM_QUOTED
  } lex_mode_t;

  lex_mode_t            mode;
  logic [7:0]           held_char;
  logic                 held_valid;
  logic                 is_num;
  logic [9:0]           txt_cnt;
  logic [LineWidth-1:0] line_cnt;
  logic [CfgWidth-1:0]  id_limit;

  token_t expected_tokens[$];

  function automatic logic [9:0] eff_limit();
    return (id_limit == '0) ? 10'd1 : id_limit;
  endfunction

  function automatic logic ends_bare(input logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChNl || c == ChVt || c == ChFf ||
           c == ChCr || c == ChLParen || c == ChRParen || c == ChSemi || c == ChBar;
  endfunction

  function automatic token_kind_t text_kind();
    return is_num ? TOK_NUMBER : TOK_IDENT;
  endfunction

  task automatic push_token(input token_kind_t k, input logic [7:0] b, input logic v,
                            input logic e, input logic lim);
    token_t t;
    t.token_kind     = k;
    t.text_byte      = b;
    t.text_valid     = v;
    t.token_end      = e;
    t.length_limited = lim;
    t.line_number    = line_cnt;
    expected_tokens.push_back(t);
  endtask

  task automatic bump_line();
    if (line_cnt != LineMax) line_cnt++;
  endtask

  // Hold the newest text byte back so the last one can carry token_end.
  task automatic add_text(input logic [7:0] c);
    if (txt_cnt < eff_limit()) begin
      if (held_valid) push_token(text_kind(), held_char, 1'b1, 1'b0, 1'b0);
      held_char  = c;
      held_valid = 1'b1;
      txt_cnt++;
    end
  endtask

  task automatic close_text();
    logic lim;
    lim = (txt_cnt >= eff_limit());
    push_token(text_kind(), held_valid ? held_char : 8'h00, held_valid, 1'b1, lim);
    held_valid = 1'b0;
    held_char  = 8'h00;
    txt_cnt    = '0;
    is_num     = 1'b0;
    mode       = LM_IDLE;
  endtask

  task automatic lex_char(input logic [7:0] c, input logic eoi);
    logic rescan;
    rescan = 1'b0;
    case (mode)
      LM_COMMENT: begin
        if (eoi) begin
          mode = LM_IDLE;
          push_token(TOK_EOI, 8'h00, 1'b0, 1'b1, 1'b0);
        end else if (c == ChNl) begin
          bump_line();
          mode = LM_IDLE;
        end
      end
      LM_COLON: begin
        if (eoi) begin
          close_text();
          rescan = 1'b1;
        end else begin
          is_num     = 1'b0;
          held_char  = c;
          held_valid = 1'b1;
          txt_cnt    = 10'd1;
          mode       = LM_TEXT;
        end
      end
      LM_TEXT: begin
        if (!eoi && !ends_bare(c)) begin
          add_text(c);
        end else begin
          close_text();
          rescan = 1'b1;
        end
      end
      LM_QUOTED: begin
        if (eoi) begin
          close_text();
          rescan = 1'b1;
        end else if (c == ChBar) begin
          close_text();
        end else begin
          add_text(c);
        end
      end
      default: begin
        mode   = LM_IDLE;
        rescan = 1'b1;
      end
    endcase

    // The terminating character starts the next token.
    if (rescan) begin
      if (eoi) begin
        push_token(TOK_EOI, 8'h00, 1'b0, 1'b1, 1'b0);
      end else begin
        case (c)
          ChSpace, ChTab, ChCr: ;
          ChNl:     bump_line();
          ChSemi:   mode = LM_COMMENT;
          ChLParen: push_token(TOK_LBRACKET, 8'h00, 1'b0, 1'b1, 1'b0);
          ChRParen: push_token(TOK_RBRACKET, 8'h00, 1'b0, 1'b1, 1'b0);
          default: begin
            held_valid = 1'b0;
            held_char  = 8'h00;
            txt_cnt    = '0;
            is_num     = 1'b0;
            if (c == ChColon) begin
              mode = LM_COLON;
            end else if (c == ChBar) begin
              mode = LM_QUOTED;
            end else begin
              is_num     = (c >= ChZero && c <= ChNine);
              held_char  = c;
              held_valid = 1'b1;
              txt_cnt    = 10'd1;
              mode       = LM_TEXT;
            end
          end
        endcase
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    token_t want;
    if (rst) begin
      mode       = LM_IDLE;
      held_char  = 8'h00;
      held_valid = 1'b0;
      is_num     = 1'b0;
      txt_cnt    = '0;
      line_cnt   = '0;
      id_limit   = MaxIdLengthReset;
      mismatches = 0;
      expected_tokens.delete();
    end else begin
      if (cfg_valid && cfg_ready) id_limit = cfg_data;
      if (tok_valid && tok_ready) begin
        if (expected_tokens.size() == 0) begin
          $error("token_kind: expected none, actual %0h", tok.token_kind);
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("token_kind", 32'(want.token_kind), 32'(tok.token_kind));
          check_field("text_byte", 32'(want.text_byte), 32'(tok.text_byte));
          check_field("text_valid", 32'(want.text_valid), 32'(tok.text_valid));
          check_field("token_end", 32'(want.token_end), 32'(tok.token_end));
          check_field("length_limited", 32'(want.length_limited),
                      32'(tok.length_limited));
          check_field("line_number", 32'(want.line_number), 32'(tok.line_number));
        end
      end
      if (char_valid && char_ready) lex_char(char_req.char_byte, char_req.end_of_input);
    end
    outstanding <= expected_tokens.size();
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
module tb;
  import sel_pkg::*;

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CfgWidth-1:0] cfg_data   = '0;
  logic                char_valid = 1'b0;
  logic                char_ready;
  char_t               char_req   = '0;
  logic                tok_valid;
  logic                tok_ready  = 1'b1;
  token_t              tok;

  int   outstanding;
  int   mismatches;
  int   items_sent = 0;
  int   stall_left = 0;
  logic quiet      = 1'b0;

  localparam logic [7:0] Delims [10] = '{ChSpace, ChTab, ChNl, ChVt, ChFf, ChCr,
                                         ChLParen, ChRParen, ChSemi, ChBar};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  s_expression_lexer dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_req   (char_req),
    .tok_valid  (tok_valid),
    .tok_ready  (tok_ready),
    .tok        (tok)
  );

  token_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .char_req    (char_req),
    .tok_valid   (tok_valid),
    .tok_ready   (tok_ready),
    .tok         (tok),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  // Stall the token side in bursts of random length.
  always @(posedge clk) begin
    if (quiet) begin
      tok_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      tok_ready  <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 11);
      tok_ready  <= 1'b0;
    end else begin
      tok_ready <= 1'b1;
    end
  end

  function automatic logic is_delim(input logic [7:0] c);
    for (int i = 0; i < 10; i++) if (c == Delims[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [7:0] bare_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_delim(c));
    return c;
  endfunction

  // Mostly whitespace; brackets, bar and semicolon now and then.
  function automatic logic [7:0] pick_delim();
    int idx;
    idx = $urandom_range(0, 19);
    return (idx > 9) ? ChSpace : Delims[idx];
  endfunction

  task automatic send_char(input logic [7:0] b, input logic e);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      char_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_req   <= '{char_byte: b, end_of_input: e};
    do @(posedge clk); while (!char_ready);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  // Drain every pending token before touching the limit register.
  task automatic set_limit(input logic [CfgWidth-1:0] v);
    char_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic rand_fragment();
    int         r;
    int         n;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      send_char($urandom_range(0, 1) ? ChLParen : ChRParen, 1'b0);
    end else if (r < 30) begin
      do c = bare_byte(); while ((c >= ChZero && c <= ChNine) || c == ChColon);
      send_char(c, 1'b0);
      n = $urandom_range(0, 9);
      repeat (n) send_char(bare_byte(), 1'b0);
      send_char(pick_delim(), 1'b0);
    end else if (r < 42) begin
      send_char(8'($urandom_range(ChZero, ChNine)), 1'b0);
      n = $urandom_range(0, 8);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) send_char(bare_byte(), 1'b0);
        else send_char(8'($urandom_range(ChZero, ChNine)), 1'b0);
      end
      send_char(pick_delim(), 1'b0);
    end else if (r < 52) begin
      send_char(ChBar, 1'b0);
      n = $urandom_range(0, 10);
      repeat (n) begin
        do c = 8'($urandom_range(0, 255)); while (c == ChBar);
        send_char(c, 1'b0);
      end
      send_char(ChBar, 1'b0);
    end else if (r < 60) begin
      send_char(ChColon, 1'b0);
      send_char(8'($urandom_range(0, 255)), 1'b0);
      send_char(pick_delim(), 1'b0);
    end else if (r < 67) begin
      send_char(ChSemi, 1'b0);
      n = $urandom_range(0, 6);
      repeat (n) begin
        do c = 8'($urandom_range(0, 255)); while (c == ChNl);
        send_char(c, 1'b0);
      end
      send_char(ChNl, 1'b0);
    end else if (r < 80) begin
      case ($urandom_range(0, 3))
        0:       send_char(ChSpace, 1'b0);
        1:       send_char(ChTab, 1'b0);
        2:       send_char(ChCr, 1'b0);
        default: send_char(ChNl, 1'b0);
      endcase
    end else if (r < 85) begin
      send_char(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      send_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
    end
  endtask

  task automatic rand_phase(input logic [CfgWidth-1:0] lim, input int count);
    int start;
    set_limit(lim);
    start = items_sent;
    while (items_sent - start < count) rand_fragment();
  endtask

  initial begin
    int waited;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_limit(MaxIdLengthReset);
    send_text("(9x)\n");
    send_text(":):\n ");
    send_text("|a\nb|||");
    send_text(";\n");
    // Vertical tab and form feed start identifiers; end of input closes the token.
    send_char(ChVt, 1'b0);
    send_char(ChFf, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    send_char(ChColon, 1'b0);
    send_char(8'h5A, 1'b1);
    send_char(ChSemi, 1'b0);
    send_char(8'hA5, 1'b1);
    send_char(ChBar, 1'b0);
    send_char("q", 1'b0);
    send_char(8'hFF, 1'b1);
    set_limit('0);
    send_text("ab |xy|");

    rand_phase(10'd1023, 100);
    rand_phase(10'd1, 100);
    rand_phase(10'd2, 100);
    rand_phase(10'($urandom_range(3, 8)), 100);
    rand_phase(10'($urandom_range(9, 1023)), 90);

    quiet <= 1'b1;
    rand_phase(MaxIdLengthReset, 90);

    send_text("(s");
    send_char(8'h00, 1'b1);

    char_valid <= 1'b0;
    waited = 0;
    while (outstanding != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
